// ----- rtl/pts_pkg.sv -----
`default_nettype none
package pts_pkg;
  localparam int NumSlots = 64;
  localparam int SlotW = $clog2(NumSlots);

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_EMBRYO   = 3'd1,
    ST_SLEEPING = 3'd2,
    ST_RUNNABLE = 3'd3,
    ST_RUNNING  = 3'd4,
    ST_ZOMBIE   = 3'd5
  } slot_state_e;

  typedef enum logic [3:0] {
    CMD_ALLOC    = 4'd0,
    CMD_RUNNABLE = 4'd1,
    CMD_DISPATCH = 4'd2,
    CMD_YIELD    = 4'd3,
    CMD_SLEEP    = 4'd4,
    CMD_WAKE     = 4'd5,
    CMD_KILL     = 4'd6,
    CMD_EXIT     = 4'd7,
    CMD_REAP     = 4'd8,
    CMD_SETPRIO  = 4'd9,
    CMD_GETPRIO  = 4'd10,
    CMD_POSITION = 4'd11,
    CMD_COUNT    = 4'd12
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_FULL      = 3'd2,
    STS_NONE_RUN  = 3'd3,
    STS_BAD_PRIO  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_RR   = 2'd0,
    MODE_FIFO = 2'd1,
    MODE_PRIO = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    FSM_IDLE, FSM_SCAN, FSM_RD, FSM_EXEC, FSM_WB, FSM_OUT
  } fsm_e;

  // control bundle from sequencer to comparison unit
  typedef struct packed {
    logic             start;
    logic             step;
    logic [SlotW-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic [2:0]  state;
    logic [15:0] pid;
    logic [1:0]  prio;
    logic [31:0] created;
    logic [31:0] started;
    logic [15:0] channel;
    logic        killed;
    logic [31:0] disp;
  } slot_t;

  localparam int SlotBits = $bits(slot_t);
endpackage
`default_nettype wire

// ----- rtl/pts_ram.sv -----
`default_nettype none
module pts_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/pts_scan.sv -----
`default_nettype none
module pts_scan import pts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire scan_ctl_t        ctl_i,
  input  wire slot_t            slot_i,
  input  wire logic [3:0]       cmd_i,
  input  wire logic [15:0]      pid_i,
  input  wire logic [1:0]       mode_i,
  output logic                  found_o,
  output logic [SlotW-1:0]      hit_o,
  output logic [31:0]           count_o
);
  logic             found_q, found_d;
  logic [SlotW-1:0] hit_q, hit_d;
  logic [31:0]      count_q, count_d;
  logic [31:0]      key_q, key_d;
  logic             match, active, better;
  logic [31:0]      key;

  always_comb begin
    active = (slot_i.state == ST_SLEEPING) || (slot_i.state == ST_RUNNABLE) ||
             (slot_i.state == ST_RUNNING);
    key    = (mode_i == MODE_FIFO) ? slot_i.created : {30'd0, slot_i.prio};
    case (cmd_i)
      CMD_ALLOC:    match = slot_i.state == ST_UNUSED;
      CMD_DISPATCH: match = slot_i.state == ST_RUNNABLE;
      CMD_POSITION: match = active && slot_i.pid == pid_i;
      default:      match = slot_i.state != ST_UNUSED && slot_i.pid == pid_i;
    endcase
    better = 1'b0;
    if (match && !found_q) begin
      better = 1'b1;
    end else if (match && cmd_i == CMD_DISPATCH &&
                 (mode_i == MODE_FIFO || mode_i == MODE_PRIO)) begin
      better = key < key_q;
    end
    found_d = found_q;
    hit_d   = hit_q;
    key_d   = key_q;
    count_d = count_q;
    if (ctl_i.start) begin
      found_d = 1'b0;
      count_d = '0;
    end else if (ctl_i.step) begin
      if (better) begin
        found_d = 1'b1;
        hit_d   = ctl_i.idx;
        key_d   = key;
      end
      if (cmd_i == CMD_POSITION && active && !match && !found_q) begin
        count_d = count_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      count_q <= '0;
    end else begin
      found_q <= found_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    key_q <= key_d;
  end

  assign found_o = found_q;
  assign hit_o   = hit_q;
  assign count_o = count_q;

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> !found_q) else $error("scan start did not clear hit");
  a_hit_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && !ctl_i.start |=> found_q) else $error("hit lost");
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.start && !ctl_i.step |=> $stable(count_q)) else $error("count moved");
endmodule
`default_nettype wire

// ----- rtl/process_table_scheduler_core.sv -----
// Process table scheduler: a 64-slot task table in one RAM, run by a sequencer.
// Input channel: in_valid_i / in_stall_o with cmd, target_pid, wait_channel,
// new_priority and current_tick. One transfer is accepted when valid is high
// and stall is low; stall stays high during the clearing pass after reset,
// while an item is at work and while its result waits.
// Output channel: out_valid_o / out_stall_i, one result per item, held in an
// output register until transferred.
// Configuration: APB write of sched_mode at address 0; pready is always high.
// After reset a clearing pass writes every slot before any command is taken.
// Alloc, dispatch, position and pid commands scan the table one slot per
// cycle through the RAM read port, then read-modify-write the found slot.
// Wake visits every slot with a read and a write. A rejected priority and
// unused codes skip the scan and go straight to the result.
// The table is not ready again until the result has been transferred.
`default_nettype none
module process_table_scheduler_core import pts_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [15:0] target_pid_i,
  input  wire logic [15:0] wait_channel_i,
  input  wire logic [2:0]  new_priority_i,
  input  wire logic [31:0] current_tick_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      result_pid_o,
  output logic [5:0]       result_slot_o,
  output logic [31:0]      result_value_o,
  output logic [31:0]      result_wait_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  fsm_e state_q, state_d;
  logic [1:0]       mode_q;
  logic [15:0]      next_pid_q, next_pid_d;
  logic [SlotW-1:0] rr_q, rr_d;
  logic [SlotW:0]   cnt_q, cnt_d;
  logic             clr_q, clr_d;
  logic             ov_q, ov_d;
  logic [3:0]       cmd_q;
  logic [15:0]      pid_q, chan_q;
  logic [2:0]       prio_q;
  logic [31:0]      tick_q;
  logic [2:0]       sts_q, sts_d;
  logic [15:0]      rpid_q, rpid_d;
  logic [5:0]       rslot_q, rslot_d;
  logic [31:0]      rval_q, rval_d, rwait_q, rwait_d;
  logic             we;
  logic [SlotW-1:0] waddr, raddr, tgt_q, tgt_d, sidx;
  slot_t            wdata, rdata, mod;
  scan_ctl_t        ctl;
  logic             found;
  logic [SlotW-1:0] hit;
  logic [31:0]      pos;
  logic             accept, wake_cmd, rr_mode;

  assign pready = 1'b1;
  assign prdata = {30'd0, mode_q};
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != FSM_IDLE || clr_q || ov_q;
  assign out_valid_o = ov_q;
  assign wake_cmd = cmd_q == CMD_WAKE;
  assign rr_mode  = mode_q != MODE_FIFO && mode_q != MODE_PRIO;

  pts_ram #(.Width(SlotBits), .Depth(NumSlots)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  pts_scan u_scan (
    .clk_i, .rst_ni, .ctl_i(ctl), .slot_i(rdata), .cmd_i(cmd_q),
    .pid_i(pid_q), .mode_i(mode_q),
    .found_o(found), .hit_o(hit), .count_o(pos)
  );

  // scan order: rotated by the round-robin pointer for dispatch outside FIFO and priority modes
  always_comb begin
    sidx = cnt_q[SlotW-1:0];
    if (cmd_q == CMD_DISPATCH && rr_mode) begin
      sidx = cnt_q[SlotW-1:0] + rr_q;
    end
  end

  always_comb begin
    mod = rdata;
    sts_d = STS_OK; rpid_d = '0; rslot_d = '0; rval_d = '0; rwait_d = '0;
    case (cmd_q)
      CMD_ALLOC: begin
        mod.state = ST_EMBRYO; mod.pid = next_pid_q; mod.created = tick_q;
        mod.started = '0; mod.channel = '0; mod.killed = 1'b0; mod.disp = '0;
        rpid_d = next_pid_q; rslot_d = 6'(tgt_q);
      end
      CMD_DISPATCH: begin
        mod.state = ST_RUNNING; mod.disp = rdata.disp + 32'd1;
        if (mode_q == MODE_PRIO && rdata.started == '0) mod.started = tick_q;
        rpid_d = rdata.pid; rslot_d = 6'(tgt_q);
      end
      CMD_RUNNABLE: if (rdata.state == ST_EMBRYO) begin
        mod.state = ST_RUNNABLE; mod.started = tick_q;
      end
      CMD_YIELD: if (rdata.state == ST_RUNNING) mod.state = ST_RUNNABLE;
      CMD_SLEEP: if (rdata.state == ST_RUNNING) begin
        mod.state = ST_SLEEPING; mod.channel = chan_q;
      end
      CMD_WAKE: if (rdata.state == ST_SLEEPING && rdata.channel == chan_q)
        mod.state = ST_RUNNABLE;
      CMD_KILL: begin
        mod.killed = 1'b1;
        if (rdata.state == ST_SLEEPING) mod.state = ST_RUNNABLE;
      end
      CMD_EXIT: if (rdata.state != ST_ZOMBIE) begin
        rval_d = tick_q - rdata.created;
        rwait_d = rdata.started - rdata.created;
        mod.state = ST_ZOMBIE;
      end
      CMD_REAP: if (rdata.state == ST_ZOMBIE) begin
        rpid_d = rdata.pid; rslot_d = 6'(tgt_q);
        mod.state = ST_UNUSED; mod.pid = '0; mod.channel = '0; mod.killed = 1'b0;
      end
      CMD_SETPRIO: mod.prio = prio_q[1:0];
      CMD_GETPRIO: begin
        if (rdata.state == ST_RUNNABLE || rdata.state == ST_RUNNING) begin
          rval_d = {30'd0, rdata.prio};
        end else begin
          sts_d = STS_NOT_FOUND;
        end
      end
      CMD_COUNT: rval_d = rdata.disp;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; clr_d = clr_q; ov_d = ov_q;
    tgt_d = tgt_q; next_pid_d = next_pid_q; rr_d = rr_q;
    we = 1'b0; waddr = tgt_q; wdata = mod; raddr = sidx;
    ctl = '{start: 1'b0, step: 1'b0, idx: '0};
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (clr_q) begin
      we = 1'b1; waddr = cnt_q[SlotW-1:0]; wdata = '0;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == (SlotW+1)'(NumSlots - 1)) begin
        clr_d = 1'b0; cnt_d = '0;
      end
    end else begin
      case (state_q)
        FSM_IDLE: if (accept) begin
          cnt_d = '0; ctl.start = 1'b1;
          if (cmd_i > CMD_COUNT) begin
            state_d = FSM_WB;
          end else if (cmd_i == CMD_SETPRIO && new_priority_i > 3'd2) begin
            state_d = FSM_WB;
          end else begin
            state_d = FSM_SCAN;
          end
        end
        FSM_SCAN: begin
          // read of sidx lands next cycle; step compares the previous read
          ctl.step = cnt_q != '0 && !wake_cmd;
          ctl.idx  = tgt_q;
          tgt_d    = sidx;
          if (wake_cmd && cnt_q != '0) begin
            we = 1'b1; waddr = tgt_q;
          end
          if (cnt_q == (SlotW+1)'(NumSlots)) begin
            state_d = wake_cmd ? FSM_WB : FSM_RD;
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (wake_cmd && cnt_q != '0) state_d = FSM_SCAN;
          end
          if (wake_cmd && cnt_q != '0 && cnt_q != (SlotW+1)'(NumSlots)) begin
            // hold the count and pass through FSM_EXEC so the read after this write sees fresh data
            cnt_d = cnt_q;
            state_d = FSM_EXEC;
          end
        end
        FSM_EXEC: begin
          // wake path: issue the next read
          cnt_d = cnt_q + 1'b1;
          raddr = cnt_q[SlotW-1:0];
          tgt_d = cnt_q[SlotW-1:0];
          state_d = FSM_SCAN;
          if (cnt_q == (SlotW+1)'(NumSlots)) state_d = FSM_WB;
        end
        FSM_RD: begin
          raddr = hit;
          tgt_d = hit;
          state_d = FSM_OUT;
        end
        FSM_OUT: begin
          state_d = FSM_WB;
          if (found && cmd_q != CMD_POSITION) begin
            we = 1'b1;
            if (cmd_q == CMD_ALLOC) next_pid_d = next_pid_q + 16'd1;
            if (cmd_q == CMD_DISPATCH && rr_mode) rr_d = tgt_q + 1'b1;
          end
        end
        FSM_WB: begin
          if (!ov_q || !out_stall_i) begin
            ov_d = 1'b1; state_d = FSM_IDLE;
          end
        end
        default: state_d = FSM_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE; mode_q <= MODE_RR; next_pid_q <= 16'd1;
      rr_q <= '0; cnt_q <= '0; clr_q <= 1'b1; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; next_pid_q <= next_pid_d; rr_q <= rr_d;
      cnt_q <= cnt_d; clr_q <= clr_d; ov_q <= ov_d;
      if (psel && penable && pwrite && paddr == 2'd0) mode_q <= pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
    if (accept) begin
      cmd_q <= cmd_i; pid_q <= target_pid_i; chan_q <= wait_channel_i;
      prio_q <= new_priority_i; tick_q <= current_tick_i;
      sts_q <= (cmd_i == CMD_SETPRIO && new_priority_i > 3'd2) ? STS_BAD_PRIO : STS_OK;
      rpid_q <= '0; rslot_q <= '0; rval_q <= '0; rwait_q <= '0;
    end else if (state_q == FSM_OUT) begin
      if (cmd_q == CMD_POSITION) begin
        sts_q <= found ? STS_OK : STS_NOT_FOUND;
        rval_q <= found ? pos : 32'd0;
      end else if (!found) begin
        sts_q <= cmd_q == CMD_ALLOC ? STS_FULL :
                 cmd_q == CMD_DISPATCH ? STS_NONE_RUN : STS_NOT_FOUND;
      end else begin
        sts_q <= sts_d; rpid_q <= rpid_d; rslot_q <= rslot_d;
        rval_q <= rval_d; rwait_q <= rwait_d;
      end
    end
  end

  assign status_o = sts_q;
  assign result_pid_o = rpid_q;
  assign result_slot_o = rslot_q;
  assign result_value_o = rval_q;
  assign result_wait_o = rwait_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != FSM_IDLE |-> in_stall_o) else $error("accept while busy");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_WB && state_d == FSM_IDLE |=> out_valid_o)
    else $error("result not shown");
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> state_q == FSM_IDLE) else $error("work during clear");
endmodule
`default_nettype wire
